// ----- hw/rtl/lclp_pkg.sv -----
// Shared types, constants and tables for the label container layout parser.
package lclp_pkg;

    // Default offset counter width
    localparam int OFFSET_BITS_DEF = 32;

    // Start signature length and search constants
    localparam int unsigned SIG_LEN     = 26;
    localparam logic [31:0] MARKER_WORD = 32'hFFFE_FF00;
    localparam logic [15:0] COMP_MARK   = 16'h0100;

    // Stream widths: output tdata is the result fields padded to whole bytes
    localparam int S_TDATA_W  = 8;
    localparam int RES_BITS   = 7 * 32 + 2;
    localparam int M_TDATA_W  = ((RES_BITS + 7) / 8) * 8;

    // Parse phases
    typedef enum logic [2:0] {
        PH_SIG,
        PH_MARK,
        PH_PAD_LEN,
        PH_IMG,
        PH_PAD_CONT,
        PH_TAIL
    } phase_t;

    // One input byte of the file stream
    typedef struct packed {
        logic       last_byte;
        logic [7:0] data_byte;
    } item_t;

    // One layout report
    typedef struct packed {
        logic        ok;
        logic [31:0] meta_stop;
        logic [31:0] image0_start;
        logic [31:0] image0_end;
        logic [31:0] image1_start;
        logic [31:0] image1_end;
        logic [31:0] cont_begin;
        logic        container_compressed;
        logic [31:0] stream_len;
    } result_t;

    // Expected start signature byte at a given index
    function automatic logic [7:0] sig_byte(input logic [4:0] idx);
        logic [7:0] b;
        unique case (idx)
            5'd0:    b = 8'h0D;
            5'd1:    b = 8'h0A;
            5'd2:    b = 8'h42;
            5'd3:    b = 8'h61;
            5'd4:    b = 8'h72;
            5'd5:    b = 8'h20;
            5'd6:    b = 8'h54;
            5'd7:    b = 8'h65;
            5'd8:    b = 8'h6E;
            5'd9:    b = 8'h64;
            5'd10:   b = 8'h65;
            5'd11:   b = 8'h72;
            5'd12:   b = 8'h20;
            5'd13:   b = 8'h46;
            5'd14:   b = 8'h6F;
            5'd15:   b = 8'h72;
            5'd16:   b = 8'h6D;
            5'd17:   b = 8'h61;
            5'd18:   b = 8'h74;
            5'd19:   b = 8'h20;
            5'd20:   b = 8'h46;
            5'd21:   b = 8'h69;
            5'd22:   b = 8'h6C;
            5'd23:   b = 8'h65;
            5'd24:   b = 8'h0D;
            5'd25:   b = 8'h0A;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// ----- hw/rtl/lclp_parser.sv -----
// Per-byte layout parser: phase state, offset tracking and the final report.
module lclp_parser #(
    parameter int OFFSET_BITS = lclp_pkg::OFFSET_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  lclp_pkg::item_t   item,
    output lclp_pkg::result_t result
);
    import lclp_pkg::*;

    localparam int W  = OFFSET_BITS;
    localparam int EW = ((W > 32) ? W : 32) + 1;
    localparam logic [W-1:0] OFF_MAX = '1;

    phase_t      phase_reg,   phase_next;
    logic [W-1:0] off_reg,    off_next;
    logic [31:0] window_reg,  window_next;
    logic [4:0]  sig_idx_reg, sig_idx_next;
    logic [1:0]  fill_reg,    fill_next;
    logic [W-1:0] target_reg, target_next;
    logic        img_idx_reg, img_idx_next;
    logic [W-1:0] found_reg  [6];
    logic [W-1:0] found_next [6];
    logic        comp_reg,    comp_next;
    logic        failed_reg,  failed_next;

    // Combinational scratch
    phase_t       ph;
    logic [31:0]  wnd;
    logic [31:0]  tail_word;
    logic [1:0]   fill_base;
    logic [W-1:0] pos;
    logic [W-1:0] start_off;
    logic [EW-1:0] end_ext;
    logic         comp;
    logic         ok;

    // Next state for one byte transfer
    always_comb begin
        phase_next   = phase_reg;
        off_next     = off_reg;
        window_next  = window_reg;
        sig_idx_next = sig_idx_reg;
        fill_next    = fill_reg;
        target_next  = target_reg;
        img_idx_next = img_idx_reg;
        for (int i = 0; i < 6; i++) begin
            found_next[i] = found_reg[i];
        end
        comp_next   = comp_reg;
        failed_next = failed_reg;
        ph          = phase_reg;
        wnd         = '0;
        tail_word   = '0;
        fill_base   = '0;
        pos         = off_reg - W'(3);
        start_off   = off_reg + W'(1);
        end_ext     = '0;
        comp        = 1'b0;
        ok          = 1'b0;
        result      = '0;

        if (step) begin
            if (!failed_reg) begin
                if (off_reg == OFF_MAX) begin
                    failed_next = 1'b1;
                end else begin
                    // Leave image data once its end offset is reached
                    if (phase_reg == PH_IMG && off_reg >= target_reg) begin
                        if (!img_idx_reg) begin
                            img_idx_next = 1'b1;
                            ph = PH_PAD_LEN;
                        end else begin
                            ph = PH_PAD_CONT;
                        end
                        fill_next   = '0;
                        window_next = '0;
                    end
                    phase_next = ph;

                    unique case (ph)
                        PH_SIG: begin
                            if (sig_idx_reg >= 5'(SIG_LEN) ||
                                item.data_byte != sig_byte(sig_idx_reg)) begin
                                failed_next = 1'b1;
                            end else begin
                                sig_idx_next = sig_idx_reg + 5'd1;
                                if (sig_idx_next == 5'(SIG_LEN)) begin
                                    phase_next  = PH_MARK;
                                    window_next = '0;
                                end
                            end
                        end
                        PH_MARK: begin
                            wnd = {window_reg[23:0], item.data_byte};
                            window_next = wnd;
                            if (wnd == MARKER_WORD) begin
                                phase_next   = PH_PAD_LEN;
                                img_idx_next = 1'b0;
                                fill_next    = '0;
                                window_next  = '0;
                            end
                        end
                        PH_PAD_LEN, PH_PAD_CONT: begin
                            // Gather a little-endian word, drop it if all zero
                            wnd         = {item.data_byte, window_next[31:8]};
                            window_next = wnd;
                            fill_base   = fill_next;
                            fill_next   = fill_base + 2'd1;
                            if (fill_base == 2'd3) begin
                                fill_next = '0;
                                if (wnd != '0) begin
                                    window_next = '0;
                                    if (ph == PH_PAD_LEN) begin
                                        // Length word: place the image
                                        end_ext = EW'(start_off) + EW'(wnd);
                                        if (!img_idx_next) begin
                                            found_next[0] = pos;
                                        end
                                        if (end_ext > EW'(OFF_MAX)) begin
                                            failed_next = 1'b1;
                                        end else begin
                                            if (!img_idx_next) begin
                                                found_next[1] = start_off;
                                                found_next[2] = W'(end_ext);
                                            end else begin
                                                found_next[3] = start_off;
                                                found_next[4] = W'(end_ext);
                                            end
                                            target_next = W'(end_ext);
                                            phase_next  = PH_IMG;
                                        end
                                    end else begin
                                        // First nonzero word opens the container
                                        comp = (wnd[15:0] == COMP_MARK);
                                        found_next[5] = pos + (comp ? W'(2) : W'(0));
                                        comp_next  = comp;
                                        phase_next = PH_TAIL;
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end

            // Count the byte, saturating at the top
            if (off_reg != OFF_MAX) begin
                off_next = off_reg + W'(1);
            end

            if (item.last_byte) begin
                // Zero-pad a short final word of padding
                if (!failed_next && phase_next == PH_PAD_CONT &&
                    (fill_next == 2'd2 || fill_next == 2'd3)) begin
                    tail_word = (fill_next == 2'd2) ? {16'h0, window_next[31:16]}
                                                    : {8'h0, window_next[31:8]};
                    if (tail_word != '0) begin
                        comp = (tail_word[15:0] == COMP_MARK);
                        found_next[5] = off_next - W'(fill_next) +
                                        (comp ? W'(2) : W'(0));
                        comp_next  = comp;
                        phase_next = PH_TAIL;
                    end
                end

                // Build the report
                ok = !failed_next && phase_next == PH_TAIL;
                if (ok) begin
                    result.ok                   = 1'b1;
                    result.meta_stop            = 32'(found_next[0]);
                    result.image0_start         = 32'(found_next[1]);
                    result.image0_end           = 32'(found_next[2]);
                    result.image1_start         = 32'(found_next[3]);
                    result.image1_end           = 32'(found_next[4]);
                    result.cont_begin           = 32'(found_next[5]);
                    result.container_compressed = comp_next;
                    result.stream_len           = 32'(off_next);
                end

                // Start over for the next file
                phase_next   = PH_SIG;
                off_next     = '0;
                window_next  = '0;
                sig_idx_next = '0;
                fill_next    = '0;
                target_next  = '0;
                img_idx_next = 1'b0;
                for (int i = 0; i < 6; i++) begin
                    found_next[i] = '0;
                end
                comp_next   = 1'b0;
                failed_next = 1'b0;
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_SIG;
            off_reg     <= '0;
            window_reg  <= '0;
            sig_idx_reg <= '0;
            fill_reg    <= '0;
            target_reg  <= '0;
            img_idx_reg <= 1'b0;
            for (int i = 0; i < 6; i++) begin
                found_reg[i] <= '0;
            end
            comp_reg   <= 1'b0;
            failed_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            off_reg     <= off_next;
            window_reg  <= window_next;
            sig_idx_reg <= sig_idx_next;
            fill_reg    <= fill_next;
            target_reg  <= target_next;
            img_idx_reg <= img_idx_next;
            for (int i = 0; i < 6; i++) begin
                found_reg[i] <= found_next[i];
            end
            comp_reg   <= comp_next;
            failed_reg <= failed_next;
        end
    end

endmodule

// ----- hw/rtl/label_container_layout_parser_core.sv -----
// Top level: input register, layout parser and result register.
//
// Takes a file one byte per cycle on the s_ stream and reports the container
// layout in a single m_ transfer after the byte marked by s_tlast. One byte
// can be accepted every cycle; the only stall is when a final byte meets a
// result still waiting on m_tready. A byte passes an input register before the
// parser updates its state; for the final byte the report is then loaded into
// the result register (m_tvalid), held back while an earlier report waits.
// OFFSET_BITS sets the internal offset counter width (16 to 63); reported
// offsets are the low 32 bits.
module label_container_layout_parser_core #(
    parameter int OFFSET_BITS = lclp_pkg::OFFSET_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [lclp_pkg::S_TDATA_W-1:0]   s_tdata,  // [7:0] data_byte
    input  logic                             s_tlast,  // last_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] ok, [32:1] meta_stop, [64:33] image0_start, [96:65] image0_end,
    // [128:97] image1_start, [160:129] image1_end, [192:161] cont_begin,
    // [193] container_compressed, [225:194] stream_len, rest zero
    output logic [lclp_pkg::M_TDATA_W-1:0]   m_tdata
);
    import lclp_pkg::*;

    logic    in_valid_reg;
    item_t   item_reg;
    logic    out_free;
    logic    step;
    result_t res;
    logic    m_valid_reg;
    logic [M_TDATA_W-1:0] m_data_reg;

    // Advance the held byte unless it is final and the result slot is full
    assign out_free = !m_valid_reg || m_tready;
    assign step     = in_valid_reg && (!item_reg.last_byte || out_free);
    assign s_tready = !in_valid_reg || step;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.data_byte <= s_tdata[7:0];
            item_reg.last_byte <= s_tlast;
        end
    end

    lclp_parser #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_parser (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .item    (item_reg),
        .result  (res)
    );

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (step && item_reg.last_byte) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && item_reg.last_byte) begin
            m_data_reg <= {(M_TDATA_W - RES_BITS)'(0),
                           res.stream_len,
                           res.container_compressed,
                           res.cont_begin,
                           res.image1_end,
                           res.image1_start,
                           res.image0_end,
                           res.image0_start,
                           res.meta_stop,
                           res.ok};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ----- hw/rtl/lclp_checker.sv -----
// Port-level checks for the layout parser, bound to the top level.
module lclp_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic [lclp_pkg::S_TDATA_W-1:0] s_tdata,
    input logic                           s_tlast,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [lclp_pkg::M_TDATA_W-1:0] m_tdata
);
    import lclp_pkg::*;

    // Hold a stalled result transfer
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // A failed layout reports all offsets as zero
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[M_TDATA_W-1:1] == '0)
        else $error("failed report carries nonzero fields");

    // First image data starts right after the length word at meta_stop
    a_prefix: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[64:33] == m_tdata[32:1] + 32'd4)
        else $error("image0_start does not follow meta_stop");

    // Reset drops any pending result
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind label_container_layout_parser_core lclp_checker u_lclp_checker (.*);

// ----- sim/label_container_layout_parser_core_tb.sv -----
// Self-checking testbench for the label container layout parser core.
`timescale 1ns / 1ps

module label_container_layout_parser_core_tb;
    import lclp_pkg::*;

    localparam logic [63:0] OFFSET_LIMIT = (64'd1 << OFFSET_BITS_DEF) - 64'd1;
    localparam int          HOLD_CYCLES  = 400;
    localparam logic [8*SIG_LEN-1:0] SIGNATURE = {
        8'h0D, 8'h0A, 8'h42, 8'h61, 8'h72, 8'h20, 8'h54, 8'h65, 8'h6E, 8'h64, 8'h65, 8'h72,
        8'h20, 8'h46, 8'h6F, 8'h72, 8'h6D, 8'h61, 8'h74, 8'h20, 8'h46, 8'h69, 8'h6C, 8'h65,
        8'h0D, 8'h0A
    };

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;  // [7:0] data_byte
    logic                 s_tlast  = 1'b0; // last_byte
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [0] ok, [32:1] meta_stop, [64:33] image0_start, [96:65] image0_end,
    // [128:97] image1_start, [160:129] image1_end, [192:161] cont_begin,
    // [193] container_compressed, [225:194] stream_len, rest zero
    logic [M_TDATA_W-1:0] m_tdata;

    label_container_layout_parser_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Layout predictor state
    phase_t      lay_phase;
    logic [63:0] lay_pos;
    logic [31:0] lay_win;
    int unsigned lay_sig_idx;
    int unsigned lay_fill;
    logic [63:0] lay_target;
    logic        lay_img;
    logic [63:0] lay_found [6];
    logic        lay_comp;
    logic        lay_fail;

    result_t     layout_expect [$];
    logic [7:0]  file_q [$];
    int          mismatches    = 0;
    int          files_sent    = 0;
    int          bytes_sent    = 0;
    int          src_idle_pct  = 0;
    int          sink_idle_pct = 0;
    logic        hold_req      = 1'b0;
    logic        hold_ack      = 1'b0;
    int          hold_left     = 0;

    function automatic logic [7:0] sig_at(input int unsigned idx);
        return SIGNATURE[(SIG_LEN - 1 - idx) * 8 +: 8];
    endfunction

    function automatic void layout_clear();
        lay_phase   = PH_SIG;
        lay_pos     = '0;
        lay_win     = '0;
        lay_sig_idx = 0;
        lay_fill    = 0;
        lay_target  = '0;
        lay_img     = 1'b0;
        for (int i = 0; i < 6; i++) lay_found[i] = '0;
        lay_comp    = 1'b0;
        lay_fail    = 1'b0;
    endfunction

    function automatic void layout_container(input logic [63:0] pos, input logic [31:0] w);
        lay_comp     = (w[15:0] == COMP_MARK);
        lay_found[5] = pos + (lay_comp ? 64'd2 : 64'd0);
        lay_phase    = PH_TAIL;
    endfunction

    function automatic void layout_length(input logic [63:0] pos, input logic [31:0] len);
        logic [63:0] first;
        logic [63:0] past;
        first = pos + 64'd4;
        past  = first + {32'b0, len};
        if (!lay_img) lay_found[0] = pos;
        if (past > OFFSET_LIMIT) begin
            lay_fail = 1'b1;
            return;
        end
        lay_found[lay_img ? 3 : 1] = first;
        lay_found[lay_img ? 4 : 2] = past;
        lay_target = past;
        lay_phase  = PH_IMG;
    endfunction

    function automatic void layout_consume(input logic [7:0] b);
        logic [63:0] at;
        logic [31:0] w;
        at = lay_pos;
        // Leave the image once its last data byte has gone by
        if (lay_phase == PH_IMG && at >= lay_target) begin
            if (!lay_img) begin
                lay_img   = 1'b1;
                lay_phase = PH_PAD_LEN;
            end else begin
                lay_phase = PH_PAD_CONT;
            end
            lay_fill = 0;
            lay_win  = '0;
        end
        case (lay_phase)
            PH_SIG: begin
                if (lay_sig_idx >= SIG_LEN || b != sig_at(lay_sig_idx)) begin
                    lay_fail = 1'b1;
                end else begin
                    lay_sig_idx++;
                    if (lay_sig_idx == SIG_LEN) begin
                        lay_phase = PH_MARK;
                        lay_win   = '0;
                    end
                end
            end
            PH_MARK: begin
                lay_win = {lay_win[23:0], b};
                if (lay_win == MARKER_WORD) begin
                    lay_phase = PH_PAD_LEN;
                    lay_img   = 1'b0;
                    lay_fill  = 0;
                    lay_win   = '0;
                end
            end
            PH_PAD_LEN, PH_PAD_CONT: begin
                lay_win = {b, lay_win[31:8]};
                lay_fill++;
                if (lay_fill >= 4) begin
                    lay_fill = 0;
                    if (lay_win != 0) begin
                        w       = lay_win;
                        lay_win = '0;
                        if (lay_phase == PH_PAD_LEN) layout_length(at - 64'd3, w);
                        else layout_container(at - 64'd3, w);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // Advance the predictor by one accepted byte; queue a report on the final byte
    function automatic void predict_layout_byte(input logic [7:0] b, input logic last);
        result_t     r;
        logic [31:0] w;
        if (!lay_fail) begin
            if (lay_pos >= OFFSET_LIMIT) lay_fail = 1'b1;
            else layout_consume(b);
        end
        if (lay_pos < OFFSET_LIMIT) lay_pos++;
        if (last) begin
            // Pad a short final word with zeros
            if (!lay_fail && lay_phase == PH_PAD_CONT && lay_fill >= 2 && lay_fill <= 3) begin
                w = lay_win >> (8 * (4 - lay_fill));
                if (w != 0) layout_container(lay_pos - lay_fill, w);
            end
            r = '0;
            if (!lay_fail && lay_phase == PH_TAIL) begin
                r.ok                   = 1'b1;
                r.meta_stop            = lay_found[0][31:0];
                r.image0_start         = lay_found[1][31:0];
                r.image0_end           = lay_found[2][31:0];
                r.image1_start         = lay_found[3][31:0];
                r.image1_end           = lay_found[4][31:0];
                r.cont_begin           = lay_found[5][31:0];
                r.container_compressed = lay_comp;
                r.stream_len           = lay_pos[31:0];
            end
            layout_expect.push_back(r);
            layout_clear();
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatches < 100) $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got, input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // Compare each report transfer with the oldest prediction
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (layout_expect.size() == 0) begin
                report_mismatch("unexpected report ok", {31'b0, m_tdata[0]}, 32'b0);
            end else begin
                want = layout_expect.pop_front();
                check_field("ok", {31'b0, m_tdata[0]}, {31'b0, want.ok});
                check_field("meta_stop", m_tdata[32:1], want.meta_stop);
                check_field("image0_start", m_tdata[64:33], want.image0_start);
                check_field("image0_end", m_tdata[96:65], want.image0_end);
                check_field("image1_start", m_tdata[128:97], want.image1_start);
                check_field("image1_end", m_tdata[160:129], want.image1_end);
                check_field("cont_begin", m_tdata[192:161], want.cont_begin);
                check_field("container_compressed", {31'b0, m_tdata[193]},
                            {31'b0, want.container_compressed});
                check_field("stream_len", m_tdata[225:194], want.stream_len);
                check_field("tdata padding", 32'(m_tdata[M_TDATA_W-1:RES_BITS]), 32'b0);
            end
        end
    end

    // Drive the result-side ready: random stalls, or a long hold-off on request
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Offer one byte, idling at random first, and predict it once transferred
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_layout_byte(b, last);
    endtask

    task automatic send_file();
        for (int i = 0; i < file_q.size(); i++) send_byte(file_q[i], i == file_q.size() - 1);
        bytes_sent += file_q.size();
        files_sent++;
        file_q.delete();
    endtask

    // Stop offering and wait for every predicted report
    task automatic drain_reports();
        s_tvalid <= 1'b0;
        while (layout_expect.size() != 0) @(posedge aclk);
    endtask

    task automatic put_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) file_q.push_back(w[8*i +: 8]);
    endtask

    task automatic put_random(input int n);
        for (int i = 0; i < n; i++) file_q.push_back(8'($urandom_range(255)));
    endtask

    task automatic put_sig();
        for (int i = 0; i < SIG_LEN; i++) file_q.push_back(sig_at(i));
    endtask

    task automatic put_marker();
        put_word({MARKER_WORD[7:0], MARKER_WORD[15:8], MARKER_WORD[23:16], MARKER_WORD[31:24]});
    endtask

    task automatic put_image(input int zw, input logic [31:0] len);
        for (int i = 0; i < zw; i++) put_word(32'h0);
        put_word(len);
        // Huge lengths end the stream early anyway
        put_random(len > 64 ? 8 : int'(len));
    endtask

    // Everything after the marker: two images, padding and the container bytes
    task automatic put_body(input int zw0, input logic [31:0] len0, input int zw1,
                            input logic [31:0] len1, input int zw2, input int cont_len,
                            input logic comp);
        put_image(zw0, len0);
        put_image(zw1, len1);
        for (int i = 0; i < zw2; i++) put_word(32'h0);
        for (int i = 0; i < cont_len; i++) begin
            if (comp && i < 2) file_q.push_back(i == 0 ? 8'h00 : 8'h01);
            else if (!comp && i == 0) file_q.push_back(8'($urandom_range(255, 1)));
            else file_q.push_back(8'($urandom_range(255)));
        end
    endtask

    function automatic logic [31:0] rand_len();
        case ($urandom_range(19))
            0:       return $urandom;
            1:       return 32'hFFFF_FFF0 | 32'($urandom_range(15));
            default: return 32'($urandom_range(16, 1));
        endcase
    endfunction

    task automatic test_directed();
        // Wrong first byte, one-byte files
        file_q.push_back(8'h00); send_file();
        file_q.push_back(8'hFF); send_file();
        // Mismatch inside the signature
        put_sig(); file_q[10] = 8'h00; put_random(10); send_file();
        // End right after the signature, then no marker at all
        put_sig(); send_file();
        put_sig(); put_random(20); send_file();
        // Marker bytes left over from one file must not match in the next
        put_sig(); file_q.push_back(8'hFF); file_q.push_back(8'hFE); file_q.push_back(8'hFF);
        send_file();
        put_sig(); file_q.push_back(8'h00); file_q.push_back(8'h11); put_marker();
        put_body(0, 4, 0, 2, 0, 5, 1'b0); send_file();
        // Clean layouts, plain and compressed, with padding and partial marker noise
        put_sig(); put_marker(); put_body(0, 5, 0, 3, 0, 6, 1'b0); send_file();
        put_sig(); put_random(3); put_marker(); put_body(2, 7, 2, 16, 1, 8, 1'b1); send_file();
        put_sig();
        file_q.push_back(8'hFF); file_q.push_back(8'hFE); file_q.push_back(8'hFF);
        put_marker(); put_body(1, 1, 0, 1, 3, 4, 1'b1); send_file();
        // Early ends: in padding, in a length word, in image data
        put_sig(); put_marker(); put_word(32'h0); file_q.push_back(8'h00);
        file_q.push_back(8'h00); send_file();
        put_sig(); put_marker(); file_q.push_back(8'h05); file_q.push_back(8'h00); send_file();
        put_sig(); put_marker(); put_word(32'd8); put_random(3); send_file();
        // Second image ends exactly at the end of the stream
        put_sig(); put_marker(); put_body(0, 2, 0, 3, 0, 0, 1'b0); send_file();
        // Short final words: three bytes, two nonzero, two zero, one
        put_sig(); put_marker(); put_body(0, 2, 1, 3, 1, 3, 1'b1); send_file();
        put_sig(); put_marker(); put_body(0, 2, 0, 3, 0, 2, 1'b0); send_file();
        put_sig(); put_marker(); put_body(0, 2, 0, 3, 1, 0, 1'b0);
        file_q.push_back(8'h00); file_q.push_back(8'h00); send_file();
        put_sig(); put_marker(); put_body(0, 2, 0, 3, 0, 1, 1'b0); send_file();
        // Image ends past the offset range, and a huge length that just fits
        put_sig(); put_marker(); put_word(32'hFFFF_FFFF); put_random(4); send_file();
        put_sig(); put_marker(); put_word(32'hFFFF_FF00); put_random(6); send_file();
        put_sig(); put_marker(); put_word(32'd2); put_random(2); put_word(32'hFFFF_FFFE);
        put_random(4); send_file();
    endtask

    task automatic build_random_file();
        int kind;
        int idx;
        kind = $urandom_range(99);
        if (kind < 85) begin
            // Mostly well formed, with random lengths, padding and content
            put_sig();
            put_random($urandom_range(6));
            put_marker();
            put_body($urandom_range(2), rand_len(), $urandom_range(2), rand_len(),
                     $urandom_range(2),
                     ($urandom_range(9) == 0) ? $urandom_range(3, 1) : $urandom_range(12, 4),
                     1'($urandom_range(1)));
            if (kind >= 70) begin
                // Break it: overwrite a byte or shift the rest by one
                idx = $urandom_range(file_q.size() - 1);
                if ($urandom_range(1)) file_q[idx] = 8'($urandom_range(255));
                else file_q.insert(idx, 8'h00);
            end
        end else if (kind < 92) begin
            put_random($urandom_range(40, 1));
        end else begin
            put_sig();
            put_random($urandom_range(30, 1));
        end
        // Cut some files short anywhere
        if ($urandom_range(9) == 0) begin
            idx = $urandom_range(file_q.size(), 1);
            while (file_q.size() > idx) void'(file_q.pop_back());
        end
    endtask

    task automatic test_random(input int src_pct, input int sink_pct);
        int first_file;
        int first_byte;
        first_file    = files_sent;
        first_byte    = bytes_sent;
        src_idle_pct  = src_pct;
        sink_idle_pct <= sink_pct;
        while (files_sent - first_file < 2 || bytes_sent - first_byte < 184) begin
            build_random_file();
            send_file();
        end
    endtask

    // Hold the result side off while short files keep coming, so the input stalls
    task automatic test_backpressure();
        src_idle_pct  = 0;
        sink_idle_pct <= 0;
        hold_req      <= ~hold_req;
        for (int i = 0; i < 40; i++) begin
            put_random($urandom_range(3, 1));
            send_file();
        end
    endtask

    initial begin
        layout_clear();
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        src_idle_pct  = 10;
        sink_idle_pct <= 69;
        test_directed();
        test_random(10, 69);
        test_random(69, 10);
        test_random(0, 0);
        test_backpressure();
        drain_reports();
        repeat (10) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Bound the run
    initial begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
